[rtl/core/timer_expiry_queue_top_defines.svh]
// ---------------------------------------------------------------------------
// Timer expiry queue assertion macros
// Concurrent check macros used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef TIMER_EXPIRY_QUEUE_TOP_DEFINES_SVH
`define TIMER_EXPIRY_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTH
`define TMQ_ASSERT_IMPL(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("tmq check failed");
`define TMQ_ASSERT_NEXT(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("tmq check failed");
`else
`define TMQ_ASSERT_IMPL(name, cond, prop)
`define TMQ_ASSERT_NEXT(name, cond, prop)
`endif
`endif

[rtl/core/tmq_pkg.sv]
// ---------------------------------------------------------------------------
// Timer expiry queue package
// Sizes, codes and shared types of the timer expiry queue.
// ---------------------------------------------------------------------------
package tmq_pkg;
   localparam int NUM_TIMERS = 16;
   localparam int TIME_BITS  = 48;
   localparam int SLOT_W     = $clog2(NUM_TIMERS);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int HSLOT_W    = 4;
   localparam int GEN_W      = 8;
   localparam int STATUS_W   = 3;
   localparam int ACTION_W   = 2;
   localparam int REQ_FIELDS_W = HSLOT_W + GEN_W + 2 * TIME_BITS;
   localparam int REQ_DATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + HSLOT_W + GEN_W + 3 + TIME_BITS;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_CANCELLED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FIRED     = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_NONE_DUE  = 3'd5;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [HSLOT_W-1:0]   slot;
      logic [GEN_W-1:0]     gen;
      logic [TIME_BITS-1:0] time_val;
      logic [TIME_BITS-1:0] period;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ADD_SCAN, ST_ADD_DO, ST_CANCEL, ST_TICK_SEL, ST_RELOAD,
      ST_NEXT_SCAN, ST_EMIT
   } state_type;
endpackage

[rtl/core/tmq_front.sv]
// ---------------------------------------------------------------------------
// Timer expiry queue front end
// Accepts request words, drops unused actions and queues commands (2 deep).
// ---------------------------------------------------------------------------
module tmq_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // slot[3:0], generation[11:4], time_value, period, zero fill
   input  logic [tmq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action[1:0]
   input  logic [tmq_pkg::ACTION_W-1:0]    req_tuser,
   output tmq_pkg::queue_type              queue_out,
   input  logic                            pop
);
   localparam int TB = tmq_pkg::TIME_BITS;
   localparam int TOFS = tmq_pkg::HSLOT_W + tmq_pkg::GEN_W;

   tmq_pkg::cmd_type ent_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   tmq_pkg::cmd_type cmd;
   logic push, do_pop;

   always_comb begin
      cmd.action   = req_tuser;
      cmd.slot     = req_tdata[tmq_pkg::HSLOT_W-1:0];
      cmd.gen      = req_tdata[tmq_pkg::HSLOT_W +: tmq_pkg::GEN_W];
      cmd.time_val = req_tdata[TOFS +: TB];
      cmd.period   = req_tdata[TOFS + TB +: TB];
   end

   assign req_tready = (count_ff != 2'd2);
   // drop the unused action code
   assign push = req_tvalid && req_tready && (req_tuser == tmq_pkg::ACT_ADD ||
                 req_tuser == tmq_pkg::ACT_CANCEL || req_tuser == tmq_pkg::ACT_TICK);
   assign do_pop = pop && (count_ff != 2'd0);

   assign queue_out.valid = (count_ff != 2'd0);
   assign queue_out.cmd   = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= cmd;
   end
endmodule

[rtl/core/tmq_back.sv]
// ---------------------------------------------------------------------------
// Timer expiry queue back end
// Holds the timer table, runs add, cancel and tick commands, emits results.
// ---------------------------------------------------------------------------
module tmq_back (
   input  logic                            clock,
   input  logic                            reset,
   input  tmq_pkg::queue_type              queue_in,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[2:0], slot[6:3], generation[14:7], was_periodic, earliest_changed,
   // next_deadline, next_valid, zero fill
   output logic [tmq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   localparam int N  = tmq_pkg::NUM_TIMERS;
   localparam int SW = tmq_pkg::SLOT_W;
   localparam int CW = tmq_pkg::CNT_W;
   localparam int TB = tmq_pkg::TIME_BITS;
   localparam int GW = tmq_pkg::GEN_W;

   tmq_pkg::state_type state_ff, state_in;
   tmq_pkg::cmd_type   cmd_ff, cmd_in;
   logic [SW-1:0] idx_ff, idx_in, pick_ff, pick_in, k_ff, k_in;
   logic          any_ff, any_in, found_ff, found_in;
   logic [TB-1:0] best_ff, best_in;
   logic [N-1:0]  picked_ff, picked_in, live_ff, live_in;
   logic [CW-1:0] n_ff, n_in;
   logic [SW-1:0] order_ff [N];
   logic [GW-1:0] gen_ff [N];
   logic [TB-1:0] deadline_ff [N];
   logic [TB-1:0] period_ff [N];
   logic [tmq_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [tmq_pkg::HSLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [GW-1:0] res_gen_ff, res_gen_in;
   logic          res_chg_ff, res_chg_in;
   logic          out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic [tmq_pkg::RSP_FIELDS_W-1:0] out_data_ff, out_data_in;

   logic [SW-1:0] rd_idx, ord_k;
   logic [TB-1:0] rd_dl, rd_per, reload_dl;
   logic [TB:0]   reload_sum;
   logic [GW-1:0] rd_gen;
   logic          rd_live, scan_last, out_free, sel_cand, sel_better, k_last;
   logic          pass_found, cancel_hit, add_chg;
   logic [SW-1:0] pass_pick;
   logic          dl_we, gen_we;
   logic [SW-1:0] wr_idx;
   logic [TB-1:0] dl_wdata;
   logic [GW-1:0] gen_wdata;
   logic [tmq_pkg::STATUS_W-1:0] o_status;
   logic [tmq_pkg::HSLOT_W-1:0]  o_slot;
   logic [GW-1:0] o_gen;
   logic          o_per, o_chg;

   assign ord_k = order_ff[k_ff];

   always_comb begin
      unique case (state_ff)
         tmq_pkg::ST_ADD_DO:  rd_idx = pick_ff;
         tmq_pkg::ST_CANCEL:  rd_idx = SW'(cmd_ff.slot);
         tmq_pkg::ST_RELOAD,
         tmq_pkg::ST_EMIT:    rd_idx = ord_k;
         default:             rd_idx = idx_ff;
      endcase
   end

   assign rd_dl   = deadline_ff[rd_idx];
   assign rd_per  = period_ff[rd_idx];
   assign rd_gen  = gen_ff[rd_idx];
   assign rd_live = live_ff[rd_idx];

   assign scan_last  = (idx_ff == SW'(N - 1));
   assign k_last     = ({1'b0, k_ff} == n_ff - CW'(1));
   assign out_free   = !out_valid_ff || rsp_tready;
   assign sel_cand   = rd_live && (rd_dl <= cmd_ff.time_val) && !picked_ff[idx_ff];
   assign sel_better = !found_ff || (rd_dl < best_ff);
   assign pass_found = found_ff || sel_cand;
   assign pass_pick  = (sel_cand && sel_better) ? idx_ff : pick_ff;
   assign cancel_hit = (int'(cmd_ff.slot) < N) && rd_live && (rd_gen == cmd_ff.gen);
   assign add_chg    = !any_ff || (cmd_ff.time_val < best_ff);
   // saturate the reload at the largest time value
   assign reload_sum = {1'b0, cmd_ff.time_val} + {1'b0, rd_per};
   assign reload_dl  = reload_sum[TB] ? {TB{1'b1}} : reload_sum[TB-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmq_pkg::ST_IDLE: begin
            if (queue_in.valid) begin
               priority case (queue_in.cmd.action)
                  tmq_pkg::ACT_ADD:    state_in = tmq_pkg::ST_ADD_SCAN;
                  tmq_pkg::ACT_CANCEL: state_in = tmq_pkg::ST_CANCEL;
                  default:             state_in = tmq_pkg::ST_TICK_SEL;
               endcase
            end
         end
         tmq_pkg::ST_ADD_SCAN: if (scan_last) state_in = tmq_pkg::ST_ADD_DO;
         tmq_pkg::ST_ADD_DO:   state_in = tmq_pkg::ST_EMIT;
         tmq_pkg::ST_CANCEL:   state_in = tmq_pkg::ST_NEXT_SCAN;
         tmq_pkg::ST_TICK_SEL: begin
            if (scan_last && !pass_found)
               state_in = (n_ff == '0) ? tmq_pkg::ST_NEXT_SCAN : tmq_pkg::ST_RELOAD;
         end
         tmq_pkg::ST_RELOAD:    if (k_last) state_in = tmq_pkg::ST_NEXT_SCAN;
         tmq_pkg::ST_NEXT_SCAN: if (scan_last) state_in = tmq_pkg::ST_EMIT;
         tmq_pkg::ST_EMIT: begin
            if (out_free && (n_ff == '0 || k_last)) state_in = tmq_pkg::ST_IDLE;
         end
         default: state_in = tmq_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in = cmd_ff;       idx_in = idx_ff;     pick_in = pick_ff;  k_in = k_ff;
      any_in = any_ff;       found_in = found_ff; best_in = best_ff;
      picked_in = picked_ff; live_in = live_ff;   n_in = n_ff;
      res_status_in = res_status_ff; res_slot_in = res_slot_ff;
      res_gen_in = res_gen_ff;       res_chg_in = res_chg_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_last_in = out_last_ff;     out_data_in = out_data_ff;
      pop = 1'b0;
      dl_we = 1'b0; gen_we = 1'b0; wr_idx = rd_idx;
      dl_wdata = cmd_ff.time_val; gen_wdata = rd_gen + GW'(1);
      o_status = res_status_ff; o_slot = res_slot_ff; o_gen = res_gen_ff;
      o_per = 1'b0; o_chg = res_chg_ff;
      unique case (state_ff)
         tmq_pkg::ST_IDLE: begin
            if (queue_in.valid) begin
               pop = 1'b1;
               cmd_in = queue_in.cmd;
               idx_in = '0; any_in = 1'b0; found_in = 1'b0;
               picked_in = '0; n_in = '0; k_in = '0;
            end
         end
         tmq_pkg::ST_ADD_SCAN: begin
            if (rd_live && (!any_ff || rd_dl < best_ff)) begin
               any_in = 1'b1;
               best_in = rd_dl;
            end
            if (!rd_live && !found_ff) begin
               found_in = 1'b1;
               pick_in = idx_ff;
            end
            idx_in = scan_last ? '0 : idx_ff + SW'(1);
         end
         tmq_pkg::ST_ADD_DO: begin
            if (found_ff) begin
               dl_we = 1'b1; gen_we = 1'b1; wr_idx = pick_ff;
               live_in[pick_ff] = 1'b1;
               res_status_in = tmq_pkg::STATUS_ADDED;
               res_slot_in = tmq_pkg::HSLOT_W'(pick_ff);
               res_gen_in = gen_wdata;
               res_chg_in = add_chg;
               any_in = 1'b1;
               if (add_chg) best_in = cmd_ff.time_val;
            end else begin
               res_status_in = tmq_pkg::STATUS_FULL;
               res_slot_in = '0; res_gen_in = '0; res_chg_in = 1'b0;
            end
         end
         tmq_pkg::ST_CANCEL: begin
            res_status_in = cancel_hit ? tmq_pkg::STATUS_CANCELLED : tmq_pkg::STATUS_NOT_FOUND;
            res_slot_in = cmd_ff.slot; res_gen_in = cmd_ff.gen; res_chg_in = 1'b0;
            if (cancel_hit) live_in[rd_idx] = 1'b0;
            idx_in = '0; any_in = 1'b0;
         end
         tmq_pkg::ST_TICK_SEL: begin
            if (sel_cand && sel_better) begin
               found_in = 1'b1;
               pick_in = idx_ff;
               best_in = rd_dl;
            end
            idx_in = scan_last ? '0 : idx_ff + SW'(1);
            if (scan_last) begin
               found_in = 1'b0;
               if (pass_found) begin
                  picked_in[pass_pick] = 1'b1;
                  n_in = n_ff + CW'(1);
               end else begin
                  any_in = 1'b0; k_in = '0;
                  res_status_in = tmq_pkg::STATUS_NONE_DUE;
                  res_slot_in = '0; res_gen_in = '0; res_chg_in = 1'b0;
               end
            end
         end
         tmq_pkg::ST_RELOAD: begin
            if (rd_per != '0) begin
               dl_we = 1'b1;
               dl_wdata = reload_dl;
            end else begin
               live_in[rd_idx] = 1'b0;
            end
            k_in = k_last ? '0 : k_ff + SW'(1);
            if (k_last) begin
               idx_in = '0; any_in = 1'b0;
            end
         end
         tmq_pkg::ST_NEXT_SCAN: begin
            if (rd_live && (!any_ff || rd_dl < best_ff)) begin
               any_in = 1'b1;
               best_in = rd_dl;
            end
            idx_in = scan_last ? '0 : idx_ff + SW'(1);
         end
         tmq_pkg::ST_EMIT: begin
            if (n_ff != '0) begin
               o_status = tmq_pkg::STATUS_FIRED;
               o_slot = tmq_pkg::HSLOT_W'(ord_k);
               o_gen = rd_gen;
               o_per = (rd_per != '0);
               o_chg = 1'b0;
            end
            if (out_free) begin
               out_valid_in = 1'b1;
               out_last_in = (n_ff == '0) || k_last;
               out_data_in = {any_ff, any_ff ? best_ff : {TB{1'b0}}, o_chg, o_per,
                              o_gen, o_slot, o_status};
               k_in = k_ff + SW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmq_pkg::ST_IDLE;
         live_ff <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < N; i++) gen_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         live_ff <= live_in;
         out_valid_ff <= out_valid_in;
         if (gen_we) gen_ff[wr_idx] <= gen_wdata;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;     idx_ff <= idx_in;     pick_ff <= pick_in;  k_ff <= k_in;
      any_ff <= any_in;     found_ff <= found_in; best_ff <= best_in;
      picked_ff <= picked_in; n_ff <= n_in;
      res_status_ff <= res_status_in; res_slot_ff <= res_slot_in;
      res_gen_ff <= res_gen_in;       res_chg_ff <= res_chg_in;
      out_last_ff <= out_last_in;     out_data_ff <= out_data_in;
      if (state_ff == tmq_pkg::ST_TICK_SEL && scan_last && pass_found)
         order_ff[n_ff[SW-1:0]] <= pass_pick;
      if (dl_we) deadline_ff[wr_idx] <= dl_wdata;
      if (state_ff == tmq_pkg::ST_ADD_DO && found_ff) period_ff[pick_ff] <= cmd_ff.period;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = tmq_pkg::RSP_DATA_W'(out_data_ff);
endmodule

[rtl/core/timer_expiry_queue_top.sv]
// Add, cancel and tick commands run slot-serial scans over the timer table.
// One command is executed at a time; results leave one per cycle from a register
// while rsp_tready is high; a 2-deep command queue absorbs arrivals.
// Reset: synchronous, active high; clears state, live bits, generations and the
// output valid; other control registers are not reset.
// ---------------------------------------------------------------------------
// Timer expiry queue top level
// Ordered timer table with add, cancel and tick commands on stream ports.
// ---------------------------------------------------------------------------
`include "timer_expiry_queue_top_defines.svh"
module timer_expiry_queue_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // slot[3:0], generation[11:4], time_value[59:12], period[107:60], zero fill
   input  logic [tmq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action[1:0]
   input  logic [tmq_pkg::ACTION_W-1:0]    req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[2:0], slot[6:3], generation[14:7], was_periodic[15],
   // earliest_changed[16], next_deadline[64:17], next_valid[65], zero fill
   output logic [tmq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   tmq_pkg::queue_type queue;
   logic pop;

   tmq_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .queue_out(queue), .pop(pop)
   );

   tmq_back u_back (
      .clock(clock), .reset(reset),
      .queue_in(queue), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   localparam int NV = tmq_pkg::STATUS_W + tmq_pkg::HSLOT_W + tmq_pkg::GEN_W + 2
                       + tmq_pkg::TIME_BITS;
   logic [tmq_pkg::STATUS_W-1:0] chk_status;
   logic chk_chg, chk_next_valid;
   assign chk_status     = rsp_tdata[tmq_pkg::STATUS_W-1:0];
   assign chk_chg        = rsp_tdata[tmq_pkg::STATUS_W + tmq_pkg::HSLOT_W + tmq_pkg::GEN_W + 1];
   assign chk_next_valid = rsp_tdata[NV];

   `TMQ_ASSERT_IMPL(a_added_live, rsp_tvalid && chk_status == tmq_pkg::STATUS_ADDED, chk_next_valid)
   `TMQ_ASSERT_IMPL(a_single_last, rsp_tvalid && chk_status != tmq_pkg::STATUS_FIRED, rsp_tlast)
   `TMQ_ASSERT_IMPL(a_chg_on_add, rsp_tvalid && chk_chg, chk_status == tmq_pkg::STATUS_ADDED)
endmodule
